// ----- src/metropolis_gaussian_sampler_assert.svh -----
// Assertion macros shared by the Metropolis sampler RTL.
`ifndef METROPOLIS_GAUSSIAN_SAMPLER_ASSERT_SVH
`define METROPOLIS_GAUSSIAN_SAMPLER_ASSERT_SVH

`ifndef ASSERT_OFF
// Property checked at every clock edge outside reset.
`define MGS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition in one cycle implies a condition in the next.
`define MGS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define MGS_ASSERT(label, prop, msg)
`define MGS_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// ----- src/mgs_pkg.sv -----
// Shared types, constants and the weight table of the Metropolis sampler.
package mgs_pkg;

  localparam int COORD_FRAC_BITS    = 14;
  localparam int WEIGHT_TABLE_DEPTH = 256;
  localparam int TAYLOR_TERMS       = 24;

  localparam int COORD_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int DRAW_W    = 16;
  localparam int WEIGHT_W  = 17;
  localparam int WPROD_W   = WEIGHT_W + DRAW_W;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int R2_W      = 2 * COORD_W;
  localparam int AB_W      = 2 * COORD_W - 1;
  localparam int ROM_IDX_W = $clog2(WEIGHT_TABLE_DEPTH);
  localparam int SAMPLE_FRAC = 30;
  localparam int G_W       = SAMPLE_FRAC + 1;
  localparam int CNT_W     = 24;
  localparam int SUM_W     = 54;
  localparam int ACC_W     = 32;
  localparam int PHASE_W   = 16;

  // proposal delta has 27 fraction bits before rounding to coordinate format
  localparam int PROP_SHIFT = 27 - COORD_FRAC_BITS;
  localparam int LIM_SHIFT  = 2 * COORD_FRAC_BITS - 14;
  localparam int RIDX_SHIFT = 2 * COORD_FRAC_BITS + 2;
  localparam int T_SHIFT    = 3 * COORD_FRAC_BITS - SAMPLE_FRAC;
  localparam int CMP_W      = R2_W + LIM_SHIFT;
  localparam int RIDX_W     = R2_W + ROM_IDX_W + 1;

  localparam logic signed [PROD_W-1:0] PROP_HALF = PROD_W'(1) <<< (PROP_SHIFT - 1);
  localparam logic [G_W-1:0] ONE_Q30 = G_W'(1) << SAMPLE_FRAC;

  localparam logic [CFG_W-1:0] STEP_SIZE_RST       = 16'd18842;
  localparam logic [CFG_W-1:0] RADIUS_SQ_LIMIT_RST = 16'd49152;
  localparam logic [CFG_W-1:0] SAMPLE_INTERVAL_RST = 16'd15;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE       = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_SIZE,
    REG_RADIUS_SQ_LIMIT,
    REG_SAMPLE_INTERVAL
  } cfg_reg_e;

  typedef enum logic {
    KIND_START,
    KIND_STEP
  } item_kind_e;

  // update beat toward the accumulator block
  typedef struct packed {
    logic valid;
    logic start;
    logic accept;
    logic production;
  } acc_cmd_t;

  typedef logic [WEIGHT_W-1:0] weight_rom_t [WEIGHT_TABLE_DEPTH];

  // restoring long division, evaluated only while the table is built
  function automatic logic [63:0] const_div(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-x) with x = r2/2, as 2^46 / (Q30 Taylor sum of exp(x)), rounded
  function automatic weight_rom_t build_weight_rom();
    weight_rom_t rom;
    logic [63:0] xq;
    logic [63:0] term;
    logic [63:0] e;
    for (int i = 0; i < WEIGHT_TABLE_DEPTH; i++) begin
      xq   = (64'(i) << 31) >> ROM_IDX_W;
      term = 64'd1 << 30;
      e    = term;
      for (int k = 1; k <= TAYLOR_TERMS; k++) begin
        term = const_div((term * xq) >> 30, 64'(k));
        e    = e + term;
      end
      rom[i] = WEIGHT_W'(const_div((64'd1 << 46) + (e >> 1), e));
    end
    return rom;
  endfunction

  localparam weight_rom_t WEIGHT_ROM = build_weight_rom();

  // table row for r2: floor(r2 * depth / 4), clamped to the last row
  function automatic logic [ROM_IDX_W-1:0] rom_index(input logic [R2_W-1:0] r2);
    logic [RIDX_W-1:0] scaled;
    logic [RIDX_W-1:0] idx;
    scaled = RIDX_W'(r2) * RIDX_W'(WEIGHT_TABLE_DEPTH);
    idx    = scaled >> RIDX_SHIFT;
    if (idx > RIDX_W'(WEIGHT_TABLE_DEPTH - 1)) begin
      return ROM_IDX_W'(WEIGHT_TABLE_DEPTH - 1);
    end
    return idx[ROM_IDX_W-1:0];
  endfunction

endpackage

// ----- src/mgs_mul.sv -----
// Shared signed multiplier with registered product.
module mgs_mul import mgs_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [MUL_W-1:0]  op_a_i,
  input  logic signed [MUL_W-1:0]  op_b_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;

  assign prod_d = PROD_W'(op_a_i) * PROD_W'(op_b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// ----- src/mgs_accum.sv -----
// Sample phase, saturating counters and sums of the sampler.
`include "metropolis_gaussian_sampler_assert.svh"

module mgs_accum import mgs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  acc_cmd_t           cmd_i,
  input  logic [CFG_W-1:0]   sample_interval_i,
  input  logic [G_W-1:0]     value_i,
  input  logic [G_W-1:0]     square_i,
  output logic               sampled_o,
  output logic [CNT_W-1:0]   sample_count_o,
  output logic [SUM_W-1:0]   value_sum_o,
  output logic [SUM_W-1:0]   square_sum_o,
  output logic [ACC_W-1:0]   accept_count_o
);

  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [CNT_W-1:0]   samples_q, samples_d;
  logic [SUM_W-1:0]   vsum_q, vsum_d;
  logic [SUM_W-1:0]   ssum_q, ssum_d;
  logic [ACC_W-1:0]   moves_q, moves_d;
  logic               sampled_q, sampled_d;

  logic [CFG_W:0]   iv_eff;
  logic [PHASE_W:0] phase_inc;
  logic [SUM_W:0]   vsum_ext;
  logic [SUM_W:0]   ssum_ext;
  logic             take;

  assign iv_eff    = (sample_interval_i == '0) ? (CFG_W+1)'(1) : {1'b0, sample_interval_i};
  assign phase_inc = {1'b0, phase_q} + (PHASE_W+1)'(1);
  assign vsum_ext  = {1'b0, vsum_q} + (SUM_W+1)'(value_i);
  assign ssum_ext  = {1'b0, ssum_q} + (SUM_W+1)'(square_i);
  assign take      = cmd_i.production && (phase_q == '0);

  always_comb begin
    phase_d   = phase_q;
    samples_d = samples_q;
    vsum_d    = vsum_q;
    ssum_d    = ssum_q;
    moves_d   = moves_q;
    sampled_d = sampled_q;
    if (cmd_i.valid) begin
      sampled_d = 1'b0;
      if (cmd_i.start) begin
        phase_d   = '0;
        samples_d = '0;
        vsum_d    = '0;
        ssum_d    = '0;
        moves_d   = '0;
      end else begin
        if (cmd_i.accept && (moves_q != '1)) begin
          moves_d = moves_q + ACC_W'(1);
        end
        if (cmd_i.production) begin
          if (take) begin
            sampled_d = 1'b1;
            if (samples_q != '1) begin
              samples_d = samples_q + CNT_W'(1);
            end
            vsum_d = vsum_ext[SUM_W] ? '1 : vsum_ext[SUM_W-1:0];
            ssum_d = ssum_ext[SUM_W] ? '1 : ssum_ext[SUM_W-1:0];
          end
          // wraps once the count reaches the interval (zero acts as one)
          phase_d = ((CFG_W+1)'(phase_inc) >= iv_eff) ? '0 : phase_inc[PHASE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      samples_q <= '0;
      vsum_q    <= '0;
      ssum_q    <= '0;
      moves_q   <= '0;
      sampled_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      samples_q <= samples_d;
      vsum_q    <= vsum_d;
      ssum_q    <= ssum_d;
      moves_q   <= moves_d;
      sampled_q <= sampled_d;
    end
  end

  assign sampled_o      = sampled_q;
  assign sample_count_o = samples_q;
  assign value_sum_o    = vsum_q;
  assign square_sum_o   = ssum_q;
  assign accept_count_o = moves_q;

  `MGS_ASSERT_NEXT(a_counts_hold, !cmd_i.valid,
                   $stable(moves_q) && $stable(samples_q) && $stable(vsum_q),
                   "accumulators moved without an update beat")
  `MGS_ASSERT(a_sampled_counted, sampled_q |-> (samples_q != '0),
              "sample flagged but sample count is zero")
  `MGS_ASSERT_NEXT(a_start_clears, cmd_i.valid && cmd_i.start,
                   (samples_q == '0) && (vsum_q == '0) && (ssum_q == '0) && !sampled_q,
                   "start beat did not clear the accumulators")

endmodule

// ----- src/metropolis_gaussian_sampler.sv -----
// Top level of the Metropolis sampler: sequencer around the shared multiplier.
`include "metropolis_gaussian_sampler_assert.svh"

// Metropolis sampler for a 3-D Gaussian weight limited to r2 <= radius_sq_limit.
// One 33x33 multiplier with a registered product does all the arithmetic under
// a small sequencer, so input items are taken one at a time: a step item makes
// eleven multiplies (three proposal deltas, three squares, old weight times
// draw, then four for the sample value), and a start item skips the three
// proposal deltas. The result sits in output registers, so the next item is
// taken while a result beat still waits; the sequencer only stalls at its last
// step if a second result is ready before the first is taken. Configuration
// writes land at once and are meant for idle periods.
module metropolis_gaussian_sampler import mgs_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      kind_i,
  input  logic signed [COORD_W-1:0] offset_x_i,
  input  logic signed [COORD_W-1:0] offset_y_i,
  input  logic signed [COORD_W-1:0] offset_z_i,
  input  logic [DRAW_W-1:0]         accept_draw_i,
  input  logic                      production_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      accepted_o,
  output logic signed [COORD_W-1:0] pos_x_o,
  output logic signed [COORD_W-1:0] pos_y_o,
  output logic signed [COORD_W-1:0] pos_z_o,
  output logic                      sampled_o,
  output logic [G_W-1:0]            sample_value_o,
  output logic [CNT_W-1:0]          sample_count_o,
  output logic [SUM_W-1:0]          value_sum_o,
  output logic [SUM_W-1:0]          square_sum_o,
  output logic [ACC_W-1:0]          accept_count_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DX,
    S_DY,
    S_DZ,
    S_SQX,
    S_SQY,
    S_SQZ,
    S_WPROD,
    S_DECIDE,
    S_SAB,
    S_SABC,
    S_STT,
    S_SGG,
    S_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic [CFG_W-1:0] step_size_q, radius_sq_limit_q, sample_interval_q;

  // latched input beat
  item_kind_e               kind_q;
  logic signed [COORD_W-1:0] off_x_q, off_y_q, off_z_q;
  logic [DRAW_W-1:0]        draw_q;
  logic                     production_q;

  // walker state and scratch
  logic signed [COORD_W-1:0] coord_x_q, coord_y_q, coord_z_q;
  logic [WEIGHT_W-1:0]       weight_q;
  logic signed [COORD_W-1:0] n_x_q, n_y_q, n_z_q;
  logic                      fits_q;
  logic [R2_W-1:0]           r2_q;
  logic                      tsat_q;
  logic [G_W-1:0]            g_q;
  logic                      accepted_q;

  // output registers
  logic                      out_valid_q;
  logic                      out_acc_q;
  logic signed [COORD_W-1:0] out_x_q, out_y_q, out_z_q;
  logic [G_W-1:0]            out_g_q;

  // datapath
  logic signed [MUL_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]         prod_u;
  logic signed [COORD_W-1:0] coord_sel;
  logic signed [PROD_W-1:0]  new_c;
  logic                      new_fits;
  logic [COORD_W-1:0]        abs_x, abs_y, abs_z;
  logic [PROD_W-1:0]         t_wide;
  logic                      tsat;
  logic [SAMPLE_FRAC-1:0]    t_val;
  logic [G_W-1:0]            g_next;
  logic [G_W-1:0]            gsq;
  logic [WEIGHT_W-1:0]       wn;
  logic [CMP_W-1:0]          lim_ext;
  logic                      in_lim;
  logic                      w_ok;
  logic                      move_ok;
  logic                      in_beat;
  logic                      commit;
  acc_cmd_t                  acc_cmd;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;
  assign commit     = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  mgs_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  assign prod_u = prod;

  assign abs_x = coord_x_q[COORD_W-1] ? COORD_W'(-coord_x_q) : COORD_W'(coord_x_q);
  assign abs_y = coord_y_q[COORD_W-1] ? COORD_W'(-coord_y_q) : COORD_W'(coord_y_q);
  assign abs_z = coord_z_q[COORD_W-1] ? COORD_W'(-coord_z_q) : COORD_W'(coord_z_q);

  // proposal: round offset*h to coordinate format and add to the old coordinate
  assign new_c    = PROD_W'(coord_sel) + ((prod + PROP_HALF) >>> PROP_SHIFT);
  assign new_fits = (&new_c[PROD_W-1:COORD_W-1]) || (~|new_c[PROD_W-1:COORD_W-1]);

  assign t_wide = prod_u >> T_SHIFT;
  assign tsat   = |t_wide[PROD_W-1:SAMPLE_FRAC];
  assign t_val  = t_wide[SAMPLE_FRAC-1:0];
  assign g_next = tsat_q ? ONE_Q30 : G_W'(prod_u >> SAMPLE_FRAC);
  assign gsq    = G_W'(prod_u >> SAMPLE_FRAC);

  assign wn      = WEIGHT_ROM[rom_index(r2_q)];
  assign lim_ext = CMP_W'(radius_sq_limit_q) << LIM_SHIFT;
  assign in_lim  = CMP_W'(r2_q) <= lim_ext;
  assign w_ok    = {wn, {DRAW_W{1'b0}}} > prod_u[WPROD_W-1:0];
  assign move_ok = (kind_q == KIND_STEP) && fits_q && in_lim && w_ok;

  always_comb begin
    op_a      = '0;
    op_b      = '0;
    coord_sel = coord_x_q;
    case (state_q)
      S_DX: begin
        op_a = MUL_W'(off_x_q);
        op_b = MUL_W'(step_size_q);
      end
      S_DY: begin
        coord_sel = coord_x_q;
        op_a      = MUL_W'(off_y_q);
        op_b      = MUL_W'(step_size_q);
      end
      S_DZ: begin
        coord_sel = coord_y_q;
        op_a      = MUL_W'(off_z_q);
        op_b      = MUL_W'(step_size_q);
      end
      S_SQX: begin
        coord_sel = coord_z_q;
        op_a      = MUL_W'(n_x_q);
        op_b      = MUL_W'(n_x_q);
      end
      S_SQY: begin
        op_a = MUL_W'(n_y_q);
        op_b = MUL_W'(n_y_q);
      end
      S_SQZ: begin
        op_a = MUL_W'(n_z_q);
        op_b = MUL_W'(n_z_q);
      end
      S_WPROD: begin
        op_a = MUL_W'(weight_q);
        op_b = MUL_W'(draw_q);
      end
      S_SAB: begin
        op_a = MUL_W'(abs_x);
        op_b = MUL_W'(abs_y);
      end
      S_SABC: begin
        // |x|*|y| is on the product register this cycle
        op_a = MUL_W'(prod_u[AB_W-1:0]);
        op_b = MUL_W'(abs_z);
      end
      S_STT: begin
        op_a = MUL_W'(t_val);
        op_b = MUL_W'(t_val);
      end
      S_SGG: begin
        op_a = MUL_W'(g_next);
        op_b = MUL_W'(g_next);
      end
      S_DONE: begin
        // keep g*g on the product while the result waits
        op_a = MUL_W'(g_q);
        op_b = MUL_W'(g_q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_IDLE;
      step_size_q       <= STEP_SIZE_RST;
      radius_sq_limit_q <= RADIUS_SQ_LIMIT_RST;
      sample_interval_q <= SAMPLE_INTERVAL_RST;
      kind_q            <= KIND_START;
      off_x_q           <= '0;
      off_y_q           <= '0;
      off_z_q           <= '0;
      draw_q            <= '0;
      production_q      <= 1'b0;
      coord_x_q         <= '0;
      coord_y_q         <= '0;
      coord_z_q         <= '0;
      weight_q          <= WEIGHT_ONE;
      n_x_q             <= '0;
      n_y_q             <= '0;
      n_z_q             <= '0;
      fits_q            <= 1'b1;
      r2_q              <= '0;
      tsat_q            <= 1'b0;
      g_q               <= '0;
      accepted_q        <= 1'b0;
      out_valid_q       <= 1'b0;
      out_acc_q         <= 1'b0;
      out_x_q           <= '0;
      out_y_q           <= '0;
      out_z_q           <= '0;
      out_g_q           <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_STEP_SIZE:       step_size_q       <= cfg_data_i;
          REG_RADIUS_SQ_LIMIT: radius_sq_limit_q <= cfg_data_i;
          REG_SAMPLE_INTERVAL: sample_interval_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_beat) begin
            kind_q       <= item_kind_e'(kind_i);
            off_x_q      <= offset_x_i;
            off_y_q      <= offset_y_i;
            off_z_q      <= offset_z_i;
            draw_q       <= accept_draw_i;
            production_q <= production_i;
            n_x_q        <= offset_x_i;
            n_y_q        <= offset_y_i;
            n_z_q        <= offset_z_i;
            fits_q       <= 1'b1;
            // a start already holds its position: go straight to the squares
            state_q      <= (item_kind_e'(kind_i) == KIND_START) ? S_SQX : S_DX;
          end
        end
        S_DX: begin
          state_q <= S_DY;
        end
        S_DY: begin
          n_x_q   <= COORD_W'(new_c);
          fits_q  <= fits_q && new_fits;
          state_q <= S_DZ;
        end
        S_DZ: begin
          n_y_q   <= COORD_W'(new_c);
          fits_q  <= fits_q && new_fits;
          state_q <= S_SQX;
        end
        S_SQX: begin
          if (kind_q == KIND_STEP) begin
            n_z_q  <= COORD_W'(new_c);
            fits_q <= fits_q && new_fits;
          end
          state_q <= S_SQY;
        end
        S_SQY: begin
          r2_q    <= prod_u[R2_W-1:0];
          state_q <= S_SQZ;
        end
        S_SQZ: begin
          r2_q    <= r2_q + prod_u[R2_W-1:0];
          state_q <= S_WPROD;
        end
        S_WPROD: begin
          r2_q    <= r2_q + prod_u[R2_W-1:0];
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          accepted_q <= move_ok;
          if ((kind_q == KIND_START) || move_ok) begin
            coord_x_q <= n_x_q;
            coord_y_q <= n_y_q;
            coord_z_q <= n_z_q;
            weight_q  <= wn;
          end
          state_q <= S_SAB;
        end
        S_SAB: begin
          state_q <= S_SABC;
        end
        S_SABC: begin
          state_q <= S_STT;
        end
        S_STT: begin
          tsat_q  <= tsat;
          state_q <= S_SGG;
        end
        S_SGG: begin
          g_q     <= g_next;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (commit) begin
            out_acc_q   <= accepted_q;
            out_x_q     <= coord_x_q;
            out_y_q     <= coord_y_q;
            out_z_q     <= coord_z_q;
            out_g_q     <= g_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    acc_cmd.valid      = commit;
    acc_cmd.start      = (kind_q == KIND_START);
    acc_cmd.accept     = accepted_q;
    acc_cmd.production = production_q && (kind_q == KIND_STEP);
  end

  mgs_accum u_accum (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (acc_cmd),
    .sample_interval_i (sample_interval_q),
    .value_i           (g_q),
    .square_i          (gsq),
    .sampled_o         (sampled_o),
    .sample_count_o    (sample_count_o),
    .value_sum_o       (value_sum_o),
    .square_sum_o      (square_sum_o),
    .accept_count_o    (accept_count_o)
  );

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = out_acc_q;
  assign pos_x_o        = out_x_q;
  assign pos_y_o        = out_y_q;
  assign pos_z_o        = out_z_q;
  assign sample_value_o = out_g_q;

  `MGS_ASSERT_NEXT(a_busy_after_beat, in_beat, !in_ready_o,
                   "input taken while an item is in flight")
  `MGS_ASSERT_NEXT(a_coord_hold, state_q != S_DECIDE,
                   $stable(coord_x_q) && $stable(coord_y_q) && $stable(coord_z_q),
                   "walker position changed outside the decision step")
  `MGS_ASSERT(a_accept_fits, ((state_q == S_DONE) && accepted_q) |->
              (fits_q && (kind_q == KIND_STEP)),
              "move accepted without an in-range step proposal")

endmodule
